/* src/qnorm_pkg.sv */
// Shared types and constants for the quaternion normalizer.
// No dependencies; every other file in src imports this package.
package qnorm_pkg;

	localparam int COMP_W = 16;
	localparam int SUM_W  = 34;
	localparam int LEN_W  = 17;

	typedef logic signed [COMP_W-1:0] comp_t;

	// Four components of one quaternion travel together.
	typedef struct packed {
		comp_t w;
		comp_t x;
		comp_t y;
		comp_t z;
	} quat_t;

	// Work item passed from the front part to the back part.
	typedef struct packed {
		quat_t            q;
		logic [SUM_W-1:0] sum;
		logic             zero;
	} work_t;

endpackage

/* src/qnorm_front.sv */
// Front part: accepts a quaternion, squares the components and sums them.
// Depends on qnorm_pkg.
module qnorm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  qnorm_pkg::quat_t in_q,
	output logic             out_vld,
	output qnorm_pkg::work_t out_work
);
	import qnorm_pkg::*;

	logic                 vld_s1;
	quat_t                q_s1;
	logic [2*COMP_W-1:0]  sq_s1 [4];
	logic                 vld_s2;
	work_t                work_s2;

	// Stage 1: one multiplier per component.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		q_s1     <= in_q;
		sq_s1[0] <= 32'(in_q.w * in_q.w);
		sq_s1[1] <= 32'(in_q.x * in_q.x);
		sq_s1[2] <= 32'(in_q.y * in_q.y);
		sq_s1[3] <= 32'(in_q.z * in_q.z);
	end

	// Stage 2: sum of squares and zero detect.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		work_s2.q    <= q_s1;
		work_s2.sum  <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1])
			+ SUM_W'(sq_s1[2]) + SUM_W'(sq_s1[3]);
		work_s2.zero <= (q_s1 == '0);
	end

	assign out_vld  = vld_s2;
	assign out_work = work_s2;
endmodule

/* src/qnorm_queue.sv */
// Short queue between the front and back parts.
// Depends on qnorm_pkg.
module qnorm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_vld,
	input  qnorm_pkg::work_t wr_work,
	output logic             rd_vld,
	output qnorm_pkg::work_t rd_work
);
	import qnorm_pkg::*;

	// The back part never stalls, so one registered entry is enough.
	logic  vld_q;
	work_t work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= wr_vld;
		end
	end

	always_ff @(posedge clk) begin
		work_q <= wr_work;
	end

	assign rd_vld  = vld_q;
	assign rd_work = work_q;
endmodule

/* src/qnorm_back.sv */
// Back part: pipelined square root, then four pipelined dividers with saturation.
// Depends on qnorm_pkg.
module qnorm_back #(
	parameter int FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  qnorm_pkg::work_t in_work,
	output logic             out_vld,
	output qnorm_pkg::quat_t out_q,
	output logic             out_zero
);
	import qnorm_pkg::*;

	localparam int RS = LEN_W;
	localparam int NW = COMP_W + FRAC_BITS;
	localparam int DS = NW;
	localparam logic [NW-1:0] MAXP = NW'(32767);
	localparam logic [NW-1:0] MAXN = NW'(32768);
	localparam logic [COMP_W-1:0] ONE_SAT =
		(FRAC_BITS >= COMP_W - 1) ? COMP_W'(32767) : COMP_W'(1 << FRAC_BITS);

	// Root pipeline: one result bit per stage.
	logic             r_vld [RS+1];
	logic [SUM_W-1:0] r_rem [RS+1];
	logic [LEN_W-1:0] r_res [RS+1];
	quat_t            r_q   [RS+1];
	logic             r_z   [RS+1];

	assign r_vld[0] = in_vld;
	assign r_rem[0] = in_work.sum;
	assign r_res[0] = '0;
	assign r_q[0]   = in_work.q;
	assign r_z[0]   = in_work.zero;

	for (genvar i = 0; i < RS; i++) begin : g_root
		localparam int B = RS - 1 - i;
		logic [SUM_W+1:0] trial;
		logic             ok;
		always_comb begin
			trial = ((SUM_W+2)'(r_res[i]) << (B + 1)) + ((SUM_W+2)'(1) << (2 * B));
			ok    = (SUM_W+2)'(r_rem[i]) >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				r_vld[i+1] <= 1'b0;
			end else begin
				r_vld[i+1] <= r_vld[i];
			end
		end
		always_ff @(posedge clk) begin
			r_rem[i+1] <= ok ? SUM_W'((SUM_W+2)'(r_rem[i]) - trial) : r_rem[i];
			r_res[i+1] <= ok ? (r_res[i] | (LEN_W'(1) << B)) : r_res[i];
			r_q[i+1]   <= r_q[i];
			r_z[i+1]   <= r_z[i];
		end
	end

	// Divider setup: magnitudes and signs of the components.
	logic             d_vld [DS+1];
	logic [NW-1:0]    d_rem [DS+1][4];
	logic [NW-1:0]    d_num [DS+1][4];
	logic [NW-1:0]    d_quo [DS+1][4];
	logic [3:0]       d_neg [DS+1];
	logic [LEN_W-1:0] d_len [DS+1];
	logic             d_z   [DS+1];
	comp_t            comps [4];

	assign comps[0] = r_q[RS].w;
	assign comps[1] = r_q[RS].x;
	assign comps[2] = r_q[RS].y;
	assign comps[3] = r_q[RS].z;
	assign d_vld[0] = r_vld[RS];
	assign d_len[0] = r_res[RS];
	assign d_z[0]   = r_z[RS];

	for (genvar c = 0; c < 4; c++) begin : g_abs
		logic [COMP_W:0] mag;
		assign mag          = comps[c][COMP_W-1] ? -(COMP_W+1)'(comps[c])
			: (COMP_W+1)'(comps[c]);
		assign d_neg[0][c]  = comps[c][COMP_W-1];
		assign d_num[0][c]  = NW'(mag) << FRAC_BITS;
		assign d_rem[0][c]  = '0;
		assign d_quo[0][c]  = '0;
	end

	// Restoring division: one quotient bit per stage for each lane.
	for (genvar i = 0; i < DS; i++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d_vld[i+1] <= 1'b0;
			end else begin
				d_vld[i+1] <= d_vld[i];
			end
		end
		always_ff @(posedge clk) begin
			d_len[i+1] <= d_len[i];
			d_neg[i+1] <= d_neg[i];
			d_z[i+1]   <= d_z[i];
		end
		for (genvar c = 0; c < 4; c++) begin : g_lane
			logic [NW:0] sh;
			logic        ok;
			always_comb begin
				sh = {d_rem[i][c], d_num[i][c][NW-1]};
				ok = sh >= (NW+1)'(d_len[i]);
			end
			always_ff @(posedge clk) begin
				d_rem[i+1][c] <= ok ? NW'(sh - (NW+1)'(d_len[i])) : NW'(sh);
				d_num[i+1][c] <= d_num[i][c] << 1;
				d_quo[i+1][c] <= {d_quo[i][c][NW-2:0], ok};
			end
		end
	end

	// Saturate, apply sign, and register the result.
	logic  vld_q;
	quat_t q_q;
	logic  z_q;
	comp_t res [4];

	for (genvar c = 0; c < 4; c++) begin : g_sat
		logic [NW-1:0] qv;
		assign qv = d_quo[DS][c];
		always_comb begin
			if (d_neg[DS][c]) begin
				res[c] = (qv > MAXN) ? comp_t'(16'h8000) : comp_t'(-COMP_W'(qv));
			end else begin
				res[c] = (qv > MAXP) ? comp_t'(16'h7fff) : comp_t'(qv);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d_vld[DS];
		end
	end

	always_ff @(posedge clk) begin
		z_q <= d_z[DS];
		if (d_z[DS]) begin
			q_q <= '{w: ONE_SAT, x: '0, y: '0, z: '0};
		end else begin
			q_q <= '{w: res[0], x: res[1], y: res[2], z: res[3]};
		end
	end

	assign out_vld  = vld_q;
	assign out_q    = q_q;
	assign out_zero = z_q;
endmodule

/* src/quaternion_normalizer.sv */
// Quaternion normalizer top level: front sum of squares, queue, root and divide.
// Throughput is one quaternion per cycle; busy is always low.
// Front, queue, root, divider and output registers together set the latency.
// Reset clears all valid flags asynchronously; no result follows reset.
module quaternion_normalizer #(
	parameter int FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [15:0]  in_w,
	input  logic [15:0]  in_x,
	input  logic [15:0]  in_y,
	input  logic [15:0]  in_z,
	output logic         done,
	output logic [15:0]  out_w,
	output logic [15:0]  out_x,
	output logic [15:0]  out_y,
	output logic [15:0]  out_z,
	output logic         zero_length
);
	import qnorm_pkg::*;

	quat_t in_q;
	quat_t res_q;
	logic  f_vld;
	work_t f_work;
	logic  q_vld;
	work_t q_work;

	assign busy = 1'b0;
	assign in_q = '{w: in_w, x: in_x, y: in_y, z: in_z};

	// Front part classifies and sums.
	qnorm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_vld(start), .in_q(in_q),
		.out_vld(f_vld), .out_work(f_work)
	);

	// Queue between the parts.
	qnorm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_vld(f_vld), .wr_work(f_work),
		.rd_vld(q_vld), .rd_work(q_work)
	);

	// Back part computes the root and quotients.
	qnorm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .in_vld(q_vld), .in_work(q_work),
		.out_vld(done), .out_q(res_q), .out_zero(zero_length)
	);

	assign out_w = res_q.w;
	assign out_x = res_q.x;
	assign out_y = res_q.y;
	assign out_z = res_q.z;
endmodule
